@@ src/swsr_pkg.sv @@
// Package for the single-wire sensor reader: beat and state types, register indexes,
// phase codes shared by the step logic and the top level, and the small helper functions of the step logic.
// Depends on nothing.
package swsr_pkg;

	localparam int BYTE_BITS  = 8;
	localparam int TIMER_BITS = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

	localparam logic [CFG_IDX_W-1:0] CFG_START_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES        = 3'd4;

	localparam logic [1:0] ST_NONE     = 2'd0;
	localparam logic [1:0] ST_RESP_OK  = 2'd1;
	localparam logic [1:0] ST_RESP_TO  = 2'd2;
	localparam logic [1:0] ST_BIT_TO   = 2'd3;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START     = 4'd1,
		PH_RELEASE   = 4'd2,
		PH_RESP_LOW  = 4'd3,
		PH_RESP_HIGH = 4'd4,
		PH_RESP_END  = 4'd5,
		PH_BIT_RISE  = 4'd6,
		PH_BIT_DELAY = 4'd7,
		PH_BIT_FALL  = 4'd8
	} phase_t;

	typedef struct packed {
		logic req_type;
		logic line_level;
	} in_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       byte_valid;
		logic [7:0] byte_value;
		logic       last_byte;
		logic [1:0] status;
	} out_t;

	typedef struct packed {
		logic [15:0] start_low_ticks;
		logic [7:0]  release_ticks;
		logic [7:0]  sample_delay_ticks;
		logic [15:0] timeout_ticks;
		logic [3:0]  bytes_to_read;
	} cfg_t;

	typedef struct packed {
		phase_t                 phase;
		logic [TIMER_BITS-1:0]  tick_count;
		logic [2:0]             bit_index;
		logic [BYTE_BITS-1:0]   shift_byte;
		logic [2:0]             byte_index;
	} st_t;

	function automatic logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
	endfunction

	function automatic logic [3:0] byte_limit(input logic [3:0] n);
		logic [3:0] r;
		if (n == 4'd0) begin
			r = 4'd1;
		end else if (n > 4'd8) begin
			r = 4'd8;
		end else begin
			r = n;
		end
		return r;
	endfunction

endpackage

@@ src/swsr_step.sv @@
// Per-tick step logic of the single-wire sensor reader: next state and result beat
// from the current state, one input beat and the configuration. Uses swsr_pkg.
module swsr_step import swsr_pkg::*; (
	input  cfg_t cfg,
	input  st_t  st,
	input  in_t  item,
	output st_t  nxt,
	output out_t res
);

	phase_t                eph;
	logic [TIMER_BITS-1:0] etc;
	logic [TIMER_BITS-1:0] tc_bump;
	logic                  waiting;
	logic                  wait_exp;
	logic                  bit_last;
	logic                  byte_last;

	always_comb begin
		eph = st.phase;
		etc = st.tick_count;
		if (st.phase == PH_IDLE && item.req_type) begin
			eph = PH_START;
			etc = '0;
		end
		if (eph == PH_RELEASE && !(32'(etc) < 32'(cfg.release_ticks))) begin
			eph = PH_RESP_LOW;
			etc = '0;
		end
	end

	always_comb begin
		tc_bump   = bump(etc);
		wait_exp  = (32'(etc) + 32'd1) >= 32'(cfg.timeout_ticks);
		waiting   = (eph == PH_RESP_HIGH || eph == PH_BIT_RISE) ? !item.line_level
			: item.line_level;
		bit_last  = st.bit_index == 3'(BYTE_BITS - 1);
		byte_last = ({1'b0, st.byte_index} + 4'd1) >= byte_limit(cfg.bytes_to_read);
	end

	always_comb begin
		nxt = st;
		case (eph)
			PH_START: begin
				nxt.phase      = PH_START;
				nxt.tick_count = tc_bump;
				if (32'(tc_bump) >= 32'(cfg.start_low_ticks)) begin
					nxt.phase      = PH_RELEASE;
					nxt.tick_count = '0;
				end
			end
			PH_RELEASE: begin
				nxt.tick_count = tc_bump;
			end
			PH_RESP_LOW, PH_RESP_HIGH, PH_RESP_END: begin
				if (waiting) begin
					if (wait_exp) begin
						nxt.phase      = PH_IDLE;
						nxt.tick_count = '0;
					end else begin
						nxt.phase      = eph;
						nxt.tick_count = tc_bump;
					end
				end else if (eph == PH_RESP_END) begin
					nxt.phase      = PH_BIT_RISE;
					nxt.tick_count = '0;
					nxt.bit_index  = '0;
					nxt.shift_byte = '0;
					nxt.byte_index = '0;
				end else begin
					nxt.phase      = (eph == PH_RESP_LOW) ? PH_RESP_HIGH : PH_RESP_END;
					nxt.tick_count = '0;
				end
			end
			PH_BIT_RISE, PH_BIT_FALL: begin
				if (waiting) begin
					if (wait_exp) begin
						nxt.phase      = PH_IDLE;
						nxt.tick_count = '0;
					end else begin
						nxt.tick_count = tc_bump;
					end
				end else if (eph == PH_BIT_RISE) begin
					nxt.phase      = PH_BIT_DELAY;
					nxt.tick_count = '0;
				end else if (bit_last) begin
					nxt.tick_count = '0;
					if (byte_last) begin
						nxt.phase = PH_IDLE;
					end else begin
						nxt.phase      = PH_BIT_RISE;
						nxt.bit_index  = '0;
						nxt.shift_byte = '0;
						nxt.byte_index = st.byte_index + 3'd1;
					end
				end else begin
					nxt.phase      = PH_BIT_RISE;
					nxt.tick_count = '0;
					nxt.bit_index  = st.bit_index + 3'd1;
				end
			end
			PH_BIT_DELAY: begin
				nxt.tick_count = tc_bump;
				if (32'(tc_bump) >= 32'(cfg.sample_delay_ticks)) begin
					nxt.shift_byte = {st.shift_byte[BYTE_BITS-2:0], item.line_level};
					nxt.phase      = PH_BIT_FALL;
					nxt.tick_count = '0;
				end
			end
			default: begin
				nxt.phase = PH_IDLE;
			end
		endcase
	end

	always_comb begin
		res          = '0;
		res.busy_res = 1'b1;
		case (eph)
			PH_START: begin
				res.drive_low = 1'b1;
			end
			PH_RESP_LOW, PH_RESP_HIGH, PH_RESP_END: begin
				if (waiting) begin
					if (wait_exp) begin
						res.status = ST_RESP_TO;
					end
				end else if (eph == PH_RESP_END) begin
					res.status = ST_RESP_OK;
				end
			end
			PH_BIT_RISE, PH_BIT_FALL: begin
				if (waiting) begin
					if (wait_exp) begin
						res.status     = ST_BIT_TO;
						res.byte_valid = 1'b1;
						res.last_byte  = 1'b1;
					end
				end else if (eph == PH_BIT_FALL && bit_last) begin
					res.byte_valid = 1'b1;
					res.byte_value = st.shift_byte;
					res.last_byte  = byte_last;
				end
			end
			PH_RELEASE, PH_BIT_DELAY: begin
				res.busy_res = 1'b1;
			end
			default: begin
				res.busy_res = 1'b0;
			end
		endcase
	end

endmodule

@@ src/single_wire_sensor_reader_unit.sv @@
// Single-wire sensor reader, top level: beat handshakes, configuration registers,
// protocol state and the input and result registers. Uses swsr_pkg and swsr_step.
// An accepted input beat passes through the input register, then the result register, to its result beat.
// Throughput is one beat per cycle while out_ready is high; the protocol state advances once per beat.
// The arst_n reset returns the configuration registers to their defaults, clears the valid
// flags and returns the protocol to idle; no clearing pass is needed.
module single_wire_sensor_reader_unit import swsr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_item,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	st_t  st_q;
	st_t  st_nxt;
	logic v_s1;
	in_t  item_s1;
	logic v_s2;
	out_t res_s2;
	out_t res_nxt;
	logic adv;

	assign adv       = v_s1 && (!v_s2 || out_ready);
	assign in_ready  = !v_s1 || adv;
	assign out_valid = v_s2;
	assign out_item  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks    <= 16'd20000;
			cfg_q.release_ticks      <= 8'd30;
			cfg_q.sample_delay_ticks <= 8'd40;
			cfg_q.timeout_ticks      <= 16'd100;
			cfg_q.bytes_to_read      <= 4'd5;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_START_LOW:    cfg_q.start_low_ticks    <= cfg_data;
				CFG_RELEASE:      cfg_q.release_ticks      <= cfg_data[7:0];
				CFG_SAMPLE_DELAY: cfg_q.sample_delay_ticks <= cfg_data[7:0];
				CFG_TIMEOUT:      cfg_q.timeout_ticks      <= cfg_data;
				CFG_BYTES:        cfg_q.bytes_to_read      <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	swsr_step u_step (
		.cfg  (cfg_q),
		.st   (st_q),
		.item (item_s1),
		.nxt  (st_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			st_q <= '{phase: PH_IDLE, default: '0};
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				v_s2 <= 1'b1;
				st_q <= st_nxt;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> v_s2)
		else $error("result register not loaded after a step");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(st_q))
		else $error("protocol state moved without a beat");

	a_timeout_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (res_nxt.status == ST_RESP_TO || res_nxt.status == ST_BIT_TO)
		|=> st_q.phase == PH_IDLE)
		else $error("timeout did not return to idle");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.last_byte |-> out_item.byte_valid && out_item.busy_res)
		else $error("last byte flagged without a byte");

	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.drive_low |-> out_item.busy_res && !out_item.byte_valid)
		else $error("line driven outside a transaction");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for single_wire_sensor_reader_unit: sends tick beats shaped like sensor replies,
// predicts each result beat with its own protocol model or a scripted row and compares field by field.
// Depends on swsr_pkg and the block's RTL; reads no files.
module tb_top;
	import swsr_pkg::*;

	localparam int PHASE_BEATS = 30;
	localparam out_t IDLE_OUT = '0;

	typedef struct packed {
		logic req;
		logic line;
		logic typed;
		out_t want;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_t                   in_item = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_t                  out_item;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	single_wire_sensor_reader_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the reader: its registers and protocol state.
	cfg_t                  reg_copy;
	phase_t                ph;
	logic [TIMER_BITS-1:0] ticks;
	logic [2:0]            bit_pos;
	logic [7:0]            shifter;
	logic [2:0]            byte_pos;

	out_t awaited[$];
	int   errors = 0;
	int   received = 0;
	int   busy_beats = 0;
	int   recv_wait = 0;
	int   recv_hold = 0;
	bit   recv_burst = 1'b0;
	bit   send_burst = 1'b0;
	bit   no_idle = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#24_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	function automatic logic [TIMER_BITS-1:0] count_up(input logic [TIMER_BITS-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	function automatic bit wait_runs_out();
		if (int'(ticks) + 1 >= int'(reg_copy.timeout_ticks)) begin
			return 1'b1;
		end
		ticks = count_up(ticks);
		return 1'b0;
	endfunction

	function automatic void open_byte();
		ph = PH_BIT_RISE;
		ticks = '0;
		bit_pos = '0;
		shifter = '0;
	endfunction

	function automatic out_t reader_step(input in_t b);
		out_t r;
		logic waiting;
		int   byte_goal;
		r = '0;
		r.busy_res = 1'b1;
		byte_goal = (reg_copy.bytes_to_read == 4'd0) ? 1 :
			(reg_copy.bytes_to_read > 4'd8) ? 8 : int'(reg_copy.bytes_to_read);
		if (ph == PH_IDLE && b.req_type) begin
			ph = PH_START;
			ticks = '0;
		end
		// The response watch begins on the first tick past the release time.
		if (ph == PH_RELEASE) begin
			if (int'(ticks) < int'(reg_copy.release_ticks)) begin
				ticks = count_up(ticks);
				return r;
			end
			ph = PH_RESP_LOW;
			ticks = '0;
		end
		case (ph)
			PH_START: begin
				r.drive_low = 1'b1;
				ticks = count_up(ticks);
				if (ticks >= reg_copy.start_low_ticks) begin
					ph = PH_RELEASE;
					ticks = '0;
				end
			end
			PH_RESP_LOW, PH_RESP_HIGH, PH_RESP_END: begin
				waiting = (ph == PH_RESP_HIGH) ? ~b.line_level : b.line_level;
				if (waiting) begin
					if (wait_runs_out()) begin
						r.status = ST_RESP_TO;
						ph = PH_IDLE;
						ticks = '0;
					end
				end else if (ph == PH_RESP_END) begin
					r.status = ST_RESP_OK;
					byte_pos = '0;
					open_byte();
				end else begin
					ph = (ph == PH_RESP_LOW) ? PH_RESP_HIGH : PH_RESP_END;
					ticks = '0;
				end
			end
			PH_BIT_RISE, PH_BIT_FALL: begin
				waiting = (ph == PH_BIT_RISE) ? ~b.line_level : b.line_level;
				if (waiting) begin
					if (wait_runs_out()) begin
						r.status = ST_BIT_TO;
						r.byte_valid = 1'b1;
						r.last_byte = 1'b1;
						ph = PH_IDLE;
						ticks = '0;
					end
				end else if (ph == PH_BIT_RISE) begin
					ph = PH_BIT_DELAY;
					ticks = '0;
				end else if (int'(bit_pos) == BYTE_BITS - 1) begin
					r.byte_valid = 1'b1;
					r.byte_value = shifter;
					if (int'(byte_pos) + 1 >= byte_goal) begin
						r.last_byte = 1'b1;
						ph = PH_IDLE;
						ticks = '0;
					end else begin
						byte_pos = byte_pos + 3'd1;
						open_byte();
					end
				end else begin
					bit_pos = bit_pos + 3'd1;
					ph = PH_BIT_RISE;
					ticks = '0;
				end
			end
			PH_BIT_DELAY: begin
				ticks = count_up(ticks);
				if (int'(ticks) >= int'(reg_copy.sample_delay_ticks)) begin
					shifter = {shifter[6:0], b.line_level};
					ph = PH_BIT_FALL;
					ticks = '0;
				end
			end
			default: begin
				r.busy_res = 1'b0;
				ph = PH_IDLE;
			end
		endcase
		return r;
	endfunction

	task automatic flag(input string what, input logic [7:0] want, input logic [7:0] got);
		errors++;
		$display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		out_t want;
		if (out_valid === 1'b1 && out_ready === 1'b1) begin
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: result beat %0h arrived with none expected", $time, out_item);
			end else begin
				want = awaited.pop_front();
				if (out_item.drive_low !== want.drive_low)
					flag("drive_low", 8'(want.drive_low), 8'(out_item.drive_low));
				if (out_item.busy_res !== want.busy_res)
					flag("busy_res", 8'(want.busy_res), 8'(out_item.busy_res));
				if (out_item.byte_valid !== want.byte_valid)
					flag("byte_valid", 8'(want.byte_valid), 8'(out_item.byte_valid));
				if (out_item.byte_value !== want.byte_value)
					flag("byte_value", want.byte_value, out_item.byte_value);
				if (out_item.last_byte !== want.last_byte)
					flag("last_byte", 8'(want.last_byte), 8'(out_item.last_byte));
				if (out_item.status !== want.status)
					flag("status", 8'(want.status), 8'(out_item.status));
			end
			received++;
			recv_wait = (recv_burst || no_idle) ? 0 : $urandom_range(0, 12);
			if ($urandom_range(0, 15) == 0) recv_burst = ~recv_burst;
			// A long hold lets the block fill up and push back on its input.
			if (received % 300 == 150) recv_hold = 60;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (recv_hold > 0) begin
			out_ready <= 1'b0;
			recv_hold--;
		end else if (recv_wait > 0) begin
			out_ready <= 1'b0;
			recv_wait--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic stray();
		return $urandom_range(0, 7) == 0;
	endfunction

	function automatic int floor_one(input int v);
		return (v < 1) ? 1 : v;
	endfunction

	task automatic send_beat(input logic req, input logic line, input logic typed, input out_t want);
		int   gap;
		in_t  b;
		out_t r;
		gap = (send_burst || no_idle) ? 0 : $urandom_range(0, 12);
		if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
		b.req_type = req;
		b.line_level = line;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= b;
		do @(posedge clk); while (in_ready !== 1'b1);
		r = reader_step(b);
		if (r.busy_res) busy_beats++;
		awaited.push_back(typed ? want : r);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
	endtask

	task automatic load_settings(input cfg_t s);
		drain_results();
		put_reg(CFG_START_LOW, s.start_low_ticks);
		put_reg(CFG_RELEASE, CFG_DATA_W'(s.release_ticks));
		put_reg(CFG_SAMPLE_DELAY, CFG_DATA_W'(s.sample_delay_ticks));
		put_reg(CFG_TIMEOUT, s.timeout_ticks);
		put_reg(CFG_BYTES, CFG_DATA_W'(s.bytes_to_read));
		@(negedge clk);
		cfg_wen <= 1'b0;
		reg_copy = s;
	endtask

	task automatic hold_level(input int n, input logic line);
		repeat (n) send_beat(stray(), line, 1'b0, '0);
	endtask

	// One wait of the protocol: some ticks at the waiting level, then the edge,
	// unless the wait is meant to run out.
	task automatic pass_wait(input logic waiting_level, input bit may_fail, output bit ok);
		int limit;
		int n;
		limit = floor_one(int'(reg_copy.timeout_ticks));
		ok = 1'b1;
		if (may_fail && $urandom_range(0, 39) == 0) begin
			n = limit;
			ok = 1'b0;
		end else if (limit <= 64 && $urandom_range(0, 7) == 0) begin
			n = limit - 1;
		end else begin
			n = $urandom_range(0, (limit - 1 < 4) ? limit - 1 : 4);
		end
		hold_level(n, waiting_level);
		if (ok) hold_level(1, ~waiting_level);
	endtask

	task automatic run_read(input bit may_fail);
		bit         ok;
		logic [7:0] value;
		int         nbytes;
		int         i;
		int         j;
		nbytes = (reg_copy.bytes_to_read == 4'd0) ? 1 :
			(reg_copy.bytes_to_read > 4'd8) ? 8 : int'(reg_copy.bytes_to_read);
		send_beat(1'b1, coin(), 1'b0, '0);
		repeat (floor_one(int'(reg_copy.start_low_ticks)) - 1)
			send_beat(stray(), coin(), 1'b0, '0);
		repeat (int'(reg_copy.release_ticks)) send_beat(stray(), coin(), 1'b0, '0);
		pass_wait(1'b1, may_fail, ok);
		if (ok) pass_wait(1'b0, may_fail, ok);
		if (ok) pass_wait(1'b1, may_fail, ok);
		for (i = 0; i < nbytes && ok; i++) begin
			case ($urandom_range(0, 5))
				0: value = 8'h00;
				1: value = 8'hFF;
				default: value = 8'($urandom_range(0, 255));
			endcase
			for (j = BYTE_BITS - 1; j >= 0 && ok; j--) begin
				pass_wait(1'b0, may_fail, ok);
				if (ok) begin
					repeat (floor_one(int'(reg_copy.sample_delay_ticks)) - 1)
						send_beat(stray(), coin(), 1'b0, '0);
					send_beat(stray(), value[j], 1'b0, '0);
					pass_wait(1'b1, may_fail, ok);
				end
			end
		end
	endtask

	task automatic garble();
		send_beat(1'b1, coin(), 1'b0, '0);
		repeat ($urandom_range(5, 40)) send_beat(coin(), coin(), 1'b0, '0);
	endtask

	// A line held high makes every wait of the protocol end, so the reader goes idle.
	task automatic run_out();
		while (ph != PH_IDLE) send_beat(1'b0, 1'b1, 1'b0, '0);
	endtask

	initial begin
		script_row_t script [18];
		cfg_t        s;
		int          p;
		script = '{
			'{1'b0, 1'b0, 1'b1, IDLE_OUT},
			'{1'b0, 1'b1, 1'b1, IDLE_OUT},
			'{1'b1, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0, ST_NONE}},
			'{1'b1, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_RESP_TO}},
			'{1'b0, 1'b0, 1'b1, IDLE_OUT},
			'{1'b1, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0, ST_NONE}},
			'{1'b0, 1'b0, 1'b0, IDLE_OUT},
			'{1'b0, 1'b1, 1'b0, IDLE_OUT},
			'{1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_RESP_OK}},
			'{1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 8'h00, 1'b1, ST_BIT_TO}},
			'{1'b1, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0, ST_NONE}},
			'{1'b0, 1'b0, 1'b0, IDLE_OUT},
			'{1'b0, 1'b1, 1'b0, IDLE_OUT},
			'{1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_RESP_OK}},
			'{1'b0, 1'b1, 1'b0, IDLE_OUT},
			'{1'b0, 1'b1, 1'b0, IDLE_OUT},
			'{1'b0, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b1, 8'h00, 1'b1, ST_BIT_TO}},
			'{1'b0, 1'b0, 1'b1, IDLE_OUT}
		};
		reg_copy = '{16'd20000, 8'd30, 8'd40, 16'd100, 4'd5};
		ph = PH_IDLE;
		ticks = '0;
		bit_pos = '0;
		shifter = '0;
		byte_pos = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		load_settings('{16'd1, 8'd0, 8'd1, 16'd1, 4'd1});
		foreach (script[k])
			send_beat(script[k].req, script[k].line, script[k].typed, script[k].want);

		for (p = 0; p < 5; p++) begin
			case (p)
				0: s = '0;
				1: s = '{16'($urandom_range(1, 4)), 8'($urandom_range(0, 4)),
					8'($urandom_range(1, 5)), 16'($urandom_range(2, 8)), 4'd15};
				default: s = '{16'($urandom_range(1, 4)), 8'($urandom_range(0, 4)),
					8'($urandom_range(1, 5)), 16'($urandom_range(2, 12)),
					4'($urandom_range(1, 3))};
			endcase
			load_settings(s);
			busy_beats = 0;
			while (busy_beats < PHASE_BEATS) begin
				repeat ($urandom_range(0, 3)) send_beat(1'b0, coin(), 1'b0, '0);
				if ($urandom_range(0, 7) == 0) begin
					garble();
				end else begin
					run_read(1'b1);
				end
				run_out();
			end
		end

		// The longest timeout, run back to back.
		no_idle = 1'b1;
		load_settings('{16'd2, 8'd3, 8'd1, 16'hFFFF, 4'd1});
		run_read(1'b0);
		run_out();
		no_idle = 1'b0;

		drain_results();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
